@@ hdl/stc_pkg.sv @@
package stc_pkg;

   // capture geometry
   localparam int CAPTURE_WIDTH = 128;
   localparam int CHANNEL_DEPTH = 1024;

   localparam int COUNT_W = $clog2(CHANNEL_DEPTH + 1);
   localparam int INDEX_W = $clog2(CHANNEL_DEPTH);
   localparam int CAP_W   = $clog2(CAPTURE_WIDTH + 1);
   localparam int CMP_W   = (COUNT_W > CAP_W) ? COUNT_W : CAP_W;

   // fixed field widths
   localparam int TAG_W    = 4;
   localparam int DATA_W   = 12;
   localparam int GAIN_W   = 16;
   localparam int OFFSET_W = 6;
   localparam int PIXEL_W  = 16;
   localparam int ADDR_W   = 10;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_CH0_TAG       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CH1_TAG       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_TWO_CHANNEL   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SCALE_GAIN    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_CH0_OFFSET    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_CH1_OFFSET    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_TRIGGER_LEVEL = 3'd6;

   // register reset values
   localparam logic [TAG_W-1:0]    RST_CH0_TAG       = 4'd3;
   localparam logic [TAG_W-1:0]    RST_CH1_TAG       = 4'd9;
   localparam logic                RST_TWO_CHANNEL   = 1'b1;
   localparam logic [GAIN_W-1:0]   RST_SCALE_GAIN    = 16'd512;
   localparam logic [OFFSET_W-1:0] RST_CH0_OFFSET    = 6'd32;
   localparam logic [OFFSET_W-1:0] RST_CH1_OFFSET    = 6'd0;
   localparam logic [PIXEL_W-1:0]  RST_TRIGGER_LEVEL = 16'd32;

   typedef struct packed {
      logic step;    // a word is being processed this cycle
      logic clear;   // that word starts a new buffer
      logic select;  // that word is routed to this channel
   } chan_ctl_type;

   typedef struct packed {
      logic              store;
      logic [ADDR_W-1:0] addr;
      logic              hit;
   } chan_sts_type;

endpackage

@@ hdl/scope_trigger_capture.sv @@
// an accepted word waits in the input register; its result word, if any, goes to the result register
// throughput: one word per cycle; a stalled result register holds the input register
// pixel scaling, tag match and trigger compare sit in one stage between the two
// reset: synchronous, clears counts, trigger state and the stop flag, and loads
// the register defaults
module scope_trigger_capture
   import stc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [15:0]           req_tdata,  // sample_word[15:0]
   input  logic [0:0]            req_tuser,  // first_of_buffer[0]

   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [31:0]           rsp_tdata,  // write_address[9:0], pixel_value[25:10], zero
   output logic [1:0]            rsp_tuser,  // capture_channel[0], is_trigger[1]

   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   // configuration
   logic [TAG_W-1:0]    ch0_tag_ff, ch1_tag_ff;
   logic                two_channel_ff;
   logic [GAIN_W-1:0]   gain_ff;
   logic [OFFSET_W-1:0] ch0_offset_ff, ch1_offset_ff;
   logic [PIXEL_W-1:0]  level_ff;

   // input register
   logic              in_valid_ff;
   logic [15:0]       in_word_ff;
   logic              in_fob_ff;

   logic              stopped_ff, stopped_in;

   // result register
   logic              out_valid_ff;
   logic              out_chan_ff;
   logic [ADDR_W-1:0] out_addr_ff;
   logic [PIXEL_W-1:0] out_pixel_ff;
   logic              out_trig_ff;

   logic                       proc;
   logic                       out_load;
   logic [TAG_W-1:0]           tag;
   logic [DATA_W-1:0]          data;
   logic                       match0, match1;
   logic                       eff_stopped;
   logic [OFFSET_W-1:0]        offset;
   logic [DATA_W+GAIN_W-1:0]   product;
   logic [DATA_W:0]            sum;
   logic [PIXEL_W-1:0]         pixel;
   chan_ctl_type               ctl0, ctl1;
   chan_sts_type               sts0, sts1;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ch0_tag_ff     <= RST_CH0_TAG;
         ch1_tag_ff     <= RST_CH1_TAG;
         two_channel_ff <= RST_TWO_CHANNEL;
         gain_ff        <= RST_SCALE_GAIN;
         ch0_offset_ff  <= RST_CH0_OFFSET;
         ch1_offset_ff  <= RST_CH1_OFFSET;
         level_ff       <= RST_TRIGGER_LEVEL;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_CH0_TAG:       ch0_tag_ff     <= csr_data[TAG_W-1:0];
            REG_CH1_TAG:       ch1_tag_ff     <= csr_data[TAG_W-1:0];
            REG_TWO_CHANNEL:   two_channel_ff <= csr_data[0];
            REG_SCALE_GAIN:    gain_ff        <= csr_data[GAIN_W-1:0];
            REG_CH0_OFFSET:    ch0_offset_ff  <= csr_data[OFFSET_W-1:0];
            REG_CH1_OFFSET:    ch1_offset_ff  <= csr_data[OFFSET_W-1:0];
            REG_TRIGGER_LEVEL: level_ff       <= csr_data[PIXEL_W-1:0];
            default: ;
         endcase
      end
   end

   // the held word moves on whenever the result register has room
   assign proc       = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || proc;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_word_ff <= req_tdata;
         in_fob_ff  <= req_tuser[0];
      end
   end

   assign tag  = in_word_ff[15:12];
   assign data = in_word_ff[DATA_W-1:0];

   // channel zero wins when both tags are equal
   assign match0      = (tag == ch0_tag_ff);
   assign match1      = two_channel_ff && (tag == ch1_tag_ff) && !match0;
   assign eff_stopped = in_fob_ff ? 1'b0 : stopped_ff;

   assign offset  = match0 ? ch0_offset_ff : ch1_offset_ff;
   assign product = DATA_W'(data) * gain_ff;
   assign sum     = (DATA_W+1)'(product[DATA_W+GAIN_W-1:GAIN_W]) + (DATA_W+1)'(offset);
   assign pixel   = PIXEL_W'(sum);

   always_comb begin
      stopped_in = stopped_ff;
      if (proc) begin
         stopped_in = eff_stopped || (!match0 && !match1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stopped_ff <= 1'b0;
      end else begin
         stopped_ff <= stopped_in;
      end
   end

   assign ctl0.step   = proc;
   assign ctl0.clear  = in_fob_ff;
   assign ctl0.select = proc && !eff_stopped && match0;
   assign ctl1.step   = proc;
   assign ctl1.clear  = in_fob_ff;
   assign ctl1.select = proc && !eff_stopped && match1;

   stc_channel u_chan0 (
      .clock         (clock),
      .reset         (reset),
      .ctl           (ctl0),
      .pixel         (pixel),
      .trigger_level (level_ff),
      .sts           (sts0)
   );

   stc_channel u_chan1 (
      .clock         (clock),
      .reset         (reset),
      .ctl           (ctl1),
      .pixel         (pixel),
      .trigger_level (level_ff),
      .sts           (sts1)
   );

   assign out_load = sts0.store || sts1.store;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (proc) begin
         out_valid_ff <= out_load;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_chan_ff  <= sts1.store;
         out_addr_ff  <= sts1.store ? sts1.addr : sts0.addr;
         out_pixel_ff <= pixel;
         out_trig_ff  <= sts1.store ? sts1.hit : sts0.hit;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'd0, out_pixel_ff, out_addr_ff};
   assign rsp_tuser  = {out_trig_ff, out_chan_ff};

   // a stopped buffer produces nothing until a new buffer starts
   a_stopped_silent: assert property (@(posedge clock) disable iff (reset)
      (proc && stopped_ff && !in_fob_ff) |-> !out_load)
      else $error("result produced while buffer stopped");

   a_one_channel: assert property (@(posedge clock) disable iff (reset)
      !(sts0.store && sts1.store))
      else $error("both channels store the same word");

   a_ready_only_on_stall: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (in_valid_ff && out_valid_ff && !rsp_tready))
      else $error("input held back without a stall");

   // an unmatched tag always sets the stop flag
   a_unmatched_stops: assert property (@(posedge clock) disable iff (reset)
      (proc && !match0 && !match1) |=> stopped_ff)
      else $error("unmatched tag did not stop the buffer");

endmodule

@@ hdl/stc_channel.sv @@
module stc_channel
   import stc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  chan_ctl_type       ctl,
   input  logic [PIXEL_W-1:0] pixel,
   input  logic [PIXEL_W-1:0] trigger_level,
   output chan_sts_type       sts
);

   logic [COUNT_W-1:0] count_ff, count_in;
   logic [INDEX_W-1:0] trig_index_ff, trig_index_in;
   logic               triggered_ff, triggered_in;

   logic [COUNT_W-1:0] eff_count;
   logic [INDEX_W-1:0] eff_index;
   logic               eff_triggered;
   logic [CMP_W-1:0]   span;
   logic               open;
   logic               hit;
   logic               store;

   // state as seen by the current word, after an optional buffer restart
   assign eff_count     = ctl.clear ? '0 : count_ff;
   assign eff_index     = ctl.clear ? '0 : trig_index_ff;
   assign eff_triggered = ctl.clear ? 1'b0 : triggered_ff;

   assign span  = CMP_W'(eff_count - COUNT_W'(eff_index));
   assign open  = (span < CMP_W'(CAPTURE_WIDTH)) && (eff_count < COUNT_W'(CHANNEL_DEPTH));
   assign store = ctl.select && open;
   assign hit   = store && !eff_triggered && (pixel >= trigger_level);

   assign sts.store = store;
   assign sts.addr  = ADDR_W'(eff_count);
   assign sts.hit   = hit;

   always_comb begin
      count_in      = count_ff;
      trig_index_in = trig_index_ff;
      triggered_in  = triggered_ff;
      if (ctl.step) begin
         count_in      = store ? COUNT_W'(eff_count + 1'b1) : eff_count;
         trig_index_in = hit ? INDEX_W'(eff_count) : eff_index;
         triggered_in  = eff_triggered || hit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         trig_index_ff <= '0;
         triggered_ff  <= 1'b0;
      end else begin
         count_ff      <= count_in;
         trig_index_ff <= trig_index_in;
         triggered_ff  <= triggered_in;
      end
   end

endmodule

@@ tb/scope_trigger_capture_tb.sv @@
module scope_trigger_capture_tb;
   import stc_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int SAMPLE_MAX  = 4095;
   localparam int OFFSET_MAX  = 63;
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 3'd7;

   typedef struct packed {
      logic               chan;
      logic [ADDR_W-1:0]  addr;
      logic [PIXEL_W-1:0] pixel;
      logic               hit;
   } store_word_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [15:0]           req_tdata  = '0;   // sample_word[15:0]
   logic [0:0]            req_tuser  = '0;   // first_of_buffer[0]
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [31:0]           rsp_tdata;         // write_address[9:0], pixel_value[25:10], zero
   logic [1:0]            rsp_tuser;         // capture_channel[0], is_trigger[1]
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_data   = '0;

   scope_trigger_capture DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   // settings and capture state as the block should hold them
   logic [TAG_W-1:0]    cfg_tag [2];
   logic                cfg_two_chan;
   logic [GAIN_W-1:0]   cfg_gain;
   logic [OFFSET_W-1:0] cfg_offset [2];
   logic [PIXEL_W-1:0]  cfg_level;
   logic [COUNT_W-1:0]  fill_count [2];
   logic [COUNT_W-1:0]  trig_point [2];
   logic                triggered [2];
   logic                stopped;

   store_word_type pending_stores[$];
   int fail_count  = 0;
   int cycle_count = 0;
   int stall_left  = 0;
   bit quiet       = 1'b0;

   function automatic void clear_capture();
      for (int c = 0; c < 2; c++) begin
         fill_count[c] = '0;
         trig_point[c] = '0;
         triggered[c]  = 1'b0;
      end
      stopped = 1'b0;
   endfunction

   function automatic void load_defaults();
      cfg_tag[0]    = RST_CH0_TAG;
      cfg_tag[1]    = RST_CH1_TAG;
      cfg_two_chan  = RST_TWO_CHANNEL;
      cfg_gain      = RST_SCALE_GAIN;
      cfg_offset[0] = RST_CH0_OFFSET;
      cfg_offset[1] = RST_CH1_OFFSET;
      cfg_level     = RST_TRIGGER_LEVEL;
      clear_capture();
   endfunction

   // returns 0 when the word arrived while the buffer was already stopped
   function automatic bit capture_sample(logic [15:0] word, logic fob);
      logic [TAG_W-1:0]  tag;
      logic [DATA_W-1:0] data;
      int                ch;
      int                pix;
      store_word_type    s;
      tag  = word[15:12];
      data = word[11:0];
      if (fob)
         clear_capture();
      if (stopped)
         return 1'b0;
      if (tag == cfg_tag[0])
         ch = 0;
      else if (cfg_two_chan && tag == cfg_tag[1])
         ch = 1;
      else begin
         stopped = 1'b1;
         return 1'b1;
      end
      if (fill_count[ch] - trig_point[ch] >= CAPTURE_WIDTH)
         return 1'b1;
      if (fill_count[ch] >= CHANNEL_DEPTH)
         return 1'b1;
      pix     = ((int'(data) * int'(cfg_gain)) >> 16) + int'(cfg_offset[ch]);
      s.chan  = ch[0];
      s.addr  = fill_count[ch][ADDR_W-1:0];
      s.pixel = pix[PIXEL_W-1:0];
      s.hit   = 1'b0;
      if (!triggered[ch] && s.pixel >= cfg_level) begin
         trig_point[ch] = fill_count[ch];
         triggered[ch]  = 1'b1;
         s.hit          = 1'b1;
      end
      pending_stores.push_back(s);
      fill_count[ch]++;
      return 1'b1;
   endfunction

   function automatic void report_field(string name, int want, int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         fail_count++;
      end
   endfunction

   function automatic void check_store();
      store_word_type want;
      if (pending_stores.size() == 0) begin
         $display("%0t: unexpected word, expected none, actual tdata %h tuser %b",
                  $time, rsp_tdata, rsp_tuser);
         fail_count++;
         return;
      end
      want = pending_stores.pop_front();
      report_field("capture_channel", want.chan, rsp_tuser[0]);
      report_field("is_trigger", want.hit, rsp_tuser[1]);
      report_field("write_address", want.addr, rsp_tdata[ADDR_W-1:0]);
      report_field("pixel_value", want.pixel, rsp_tdata[ADDR_W+PIXEL_W-1:ADDR_W]);
      report_field("tdata padding", 0, rsp_tdata[31:ADDR_W+PIXEL_W]);
   endfunction

   // result side: check on each accepted word, stall in bursts
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready)
            check_store();
         if (quiet)
            rsp_tready <= 1'b1;
         else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if ($urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(0, 17);
            rsp_tready <= 1'b0;
         end else
            rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("scope_trigger_capture regression: fail");
         $finish;
      end
   end

   task automatic send_sample(input logic [15:0] word, input logic fob, output bit live);
      int gap;
      if (!quiet && $urandom_range(0, 9) == 0) begin
         gap = $urandom_range(1, 18);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      req_tuser  <= fob;
      do @(posedge clock); while (!req_tready);
      live = capture_sample(word, fob);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         REG_CH0_TAG:       cfg_tag[0]    = value[TAG_W-1:0];
         REG_CH1_TAG:       cfg_tag[1]    = value[TAG_W-1:0];
         REG_TWO_CHANNEL:   cfg_two_chan  = value[0];
         REG_SCALE_GAIN:    cfg_gain      = value[GAIN_W-1:0];
         REG_CH0_OFFSET:    cfg_offset[0] = value[OFFSET_W-1:0];
         REG_CH1_OFFSET:    cfg_offset[1] = value[OFFSET_W-1:0];
         REG_TRIGGER_LEVEL: cfg_level     = value[PIXEL_W-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic load_settings(input logic [15:0] tag0, input logic [15:0] tag1,
                                input logic [15:0] two, input logic [15:0] gain,
                                input logic [15:0] off0, input logic [15:0] off1,
                                input logic [15:0] level);
      write_reg(REG_CH0_TAG, tag0);
      write_reg(REG_CH1_TAG, tag1);
      write_reg(REG_TWO_CHANNEL, two);
      write_reg(REG_SCALE_GAIN, gain);
      write_reg(REG_CH0_OFFSET, off0);
      write_reg(REG_CH1_OFFSET, off1);
      write_reg(REG_TRIGGER_LEVEL, level);
   endtask

   // wait out the results, then the words in flight that give none
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (pending_stores.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   // one buffer: first_of_buffer, then mostly routed tags, a little noise
   task automatic send_buffer(input int length, inout int live_count);
      logic [15:0] word;
      logic        fob;
      int          r;
      bit          live;
      for (int i = 0; i < length; i++) begin
         fob = (i == 0) || ($urandom_range(0, 149) == 0);
         r   = $urandom_range(0, 99);
         if (r < 2)
            word[15:12] = 4'($urandom);
         else if (cfg_two_chan && r < 50)
            word[15:12] = cfg_tag[1];
         else
            word[15:12] = cfg_tag[0];
         case ($urandom_range(0, 15))
            0:       word[11:0] = '0;
            1:       word[11:0] = 12'(SAMPLE_MAX);
            default: word[11:0] = 12'($urandom);
         endcase
         send_sample(word, fob, live);
         if (live)
            live_count++;
         if (stopped) begin
            // a few words the stopped buffer must swallow
            repeat ($urandom_range(0, 2)) send_sample(16'($urandom), 1'b0, live);
            return;
         end
      end
   endtask

   task automatic run_capture(input int n);
      int live_count;
      int length;
      live_count = 0;
      while (live_count < n) begin
         length = ($urandom_range(0, 3) == 0) ? $urandom_range(130, 300)
                                              : $urandom_range(1, 60);
         if (length > n - live_count)
            length = n - live_count;
         send_buffer(length, live_count);
      end
   endtask

   task automatic randomize_settings();
      int pmax;
      write_reg(REG_CH0_TAG, 16'($urandom));
      if ($urandom_range(0, 7) == 0)
         write_reg(REG_CH1_TAG, {12'($urandom), cfg_tag[0]});
      else
         write_reg(REG_CH1_TAG, 16'($urandom));
      write_reg(REG_TWO_CHANNEL, 16'($urandom));
      case ($urandom_range(0, 5))
         0:       write_reg(REG_SCALE_GAIN, 16'h0000);
         1:       write_reg(REG_SCALE_GAIN, 16'hFFFF);
         default: write_reg(REG_SCALE_GAIN, 16'($urandom));
      endcase
      write_reg(REG_CH0_OFFSET, 16'($urandom));
      write_reg(REG_CH1_OFFSET, 16'($urandom));
      pmax = ((SAMPLE_MAX * int'(cfg_gain)) >> 16) + OFFSET_MAX;
      case ($urandom_range(0, 7))
         0:       write_reg(REG_TRIGGER_LEVEL, 16'h0000);
         1:       write_reg(REG_TRIGGER_LEVEL, 16'hFFFF);
         default: write_reg(REG_TRIGGER_LEVEL, 16'($urandom_range(0, pmax)));
      endcase
   endtask

   // reset settings: channel zero triggers at once, channel one never does
   task automatic test_default_capture();
      bit live;
      send_sample(16'h3000, 1'b1, live);
      send_sample(16'h3FFF, 1'b0, live);
      send_sample(16'h9000, 1'b0, live);
      send_sample(16'h9FFF, 1'b0, live);
      send_sample(16'h9ABC, 1'b0, live);
      send_sample(16'h3555, 1'b0, live);
      send_sample(16'h5123, 1'b0, live);
      send_sample(16'h3FFF, 1'b0, live);
      send_sample(16'h9FFF, 1'b0, live);
      send_sample(16'h9800, 1'b1, live);
      send_sample(16'h3001, 1'b0, live);
      send_sample(16'hF000, 1'b0, live);
      send_sample(16'h0FFF, 1'b1, live);
      drain_results();
   endtask

   task automatic test_tag_routing();
      bit live;
      // equal tags go to channel zero; full scale reaches the highest reachable pixel value
      load_settings(16'h0007, 16'h0007, 16'h0001, 16'hFFFF, 16'h003F, 16'h003F, 16'd4157);
      send_sample(16'h7FFF, 1'b1, live);
      send_sample(16'h7000, 1'b0, live);
      send_sample(16'h8FFF, 1'b0, live);
      drain_results();
      // single channel: the channel one tag no longer matches
      load_settings(16'hFFF0, 16'h000F, 16'hFFFE, 16'h0000, 16'hFFC0, 16'hFFFF, 16'h0000);
      send_sample(16'h0ABC, 1'b1, live);
      send_sample(16'hFABC, 1'b0, live);
      send_sample(16'h0123, 1'b1, live);
      drain_results();
      write_reg(REG_UNUSED, 16'hFFFF);
      send_sample(16'h0FFF, 1'b0, live);
      send_sample(16'hF555, 1'b0, live);
      drain_results();
   endtask

   task automatic test_scale_extremes();
      load_settings(16'h0002, 16'h000D, 16'h0001, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      run_capture(80);
      drain_results();
      load_settings(16'h000C, 16'h0001, 16'h0001, 16'hFFFF, 16'h003F, 16'h003F, 16'hFFFF);
      run_capture(80);
      drain_results();
   endtask

   task automatic test_random_capture();
      for (int p = 0; p < 8; p++) begin
         randomize_settings();
         run_capture(180);
         drain_results();
      end
   endtask

   task automatic test_back_to_back();
      quiet = 1'b1;
      randomize_settings();
      write_reg(REG_TWO_CHANNEL, 16'h0001);
      run_capture(200);
      drain_results();
   endtask

   initial begin
      load_defaults();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_default_capture();
      test_tag_routing();
      test_scale_extremes();
      test_random_capture();
      test_back_to_back();
      if (fail_count == 0)
         $display("scope_trigger_capture regression: pass");
      else
         $display("scope_trigger_capture regression: fail");
      $finish;
   end

endmodule
